// ===== rtl/esl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esl_pkg
// Shared widths, codes and pipeline record types of the element stream
// length block.
// ----------------------------------------------------------------------------
package esl_pkg;

   // coordinate and intermediate widths (Q16.16 coordinates, exact maths)
   localparam int CoordWidth = 32;
   localparam int TBits      = 32;
   localparam int LenWidth   = 32;
   localparam int Edges      = 4;
   localparam int DiffWidth  = CoordWidth + 1;
   localparam int ProdWidth  = DiffWidth + CoordWidth;
   localparam int WideWidth  = ProdWidth + 1;
   localparam int MagWidth   = WideWidth - 1;
   localparam int RemWidth   = MagWidth + 1;
   localparam int CutWidth   = DiffWidth + TBits + 2;
   localparam int RoundWidth = CutWidth + 1 - TBits;
   localparam int SqWidth    = 2 * LenWidth;
   localparam int SrWidth    = LenWidth + 2;

   // length status codes
   typedef logic [1:0] status_type;
   localparam status_type StatusCut     = 2'd0;
   localparam status_type StatusZeroVel = 2'd1;
   localparam status_type StatusNoCut   = 2'd2;

   // register map
   localparam logic RegCornerCount = 1'b0;
   localparam logic [2:0] CornersTri = 3'd3;
   localparam logic [2:0] CornersReset = 3'd4;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [DiffWidth-1:0]  diff_type;
   typedef logic signed [CutWidth-1:0]   cut_type;

   typedef struct packed {
      coord_type [3:0] x;
      coord_type [3:0] y;
      coord_type       vx;
      coord_type       vy;
      coord_type       px;
      coord_type       py;
      logic            is_tri;
   } elem_type;

   typedef struct packed {
      logic     zero_vel;
      logic     is_tri;
      diff_type zdx;
      diff_type zdy;
   } common_type;

   typedef struct packed {
      logic                ok;
      logic                eq;
      logic [MagWidth-1:0] ad;
      logic [RemWidth-1:0] rem;
      logic [TBits-1:0]    q;
      diff_type            ex;
      diff_type            ey;
      coord_type           xi;
      coord_type           yi;
   } edge_type;

   typedef struct packed {
      edge_type [Edges-1:0] e;
      common_type           c;
   } front_type;

   typedef struct packed {
      logic [SqWidth-1:0]  n;
      logic [SrWidth-1:0]  rem;
      logic [LenWidth-1:0] root;
      logic                sat;
      status_type          status;
   } sq_type;

   typedef struct packed {
      logic [LenWidth-1:0] length;
      status_type          status;
   } result_type;

endpackage

// ===== rtl/esl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esl_front
// Edge set-up: differences, cross products, parameter sign and range test.
// Five register stages.
// ----------------------------------------------------------------------------
module esl_front import esl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  elem_type  in_data,
   output logic      out_valid,
   output front_type out_data
);

   typedef logic signed [ProdWidth-1:0] prod_type;
   typedef logic signed [WideWidth-1:0] wide_type;

   typedef struct packed {
      diff_type [3:0]  ex;
      diff_type [3:0]  ey;
      diff_type [3:0]  ax;
      diff_type [3:0]  ay;
      coord_type [3:0] xi;
      coord_type [3:0] yi;
      coord_type       vx;
      coord_type       vy;
      common_type      c;
   } f1_type;

   typedef struct packed {
      prod_type [3:0]  p1;
      prod_type [3:0]  p2;
      prod_type [3:0]  p3;
      prod_type [3:0]  p4;
      diff_type [3:0]  ex;
      diff_type [3:0]  ey;
      coord_type [3:0] xi;
      coord_type [3:0] yi;
      common_type      c;
   } f2_type;

   typedef struct packed {
      wide_type [3:0]  den;
      wide_type [3:0]  num;
      diff_type [3:0]  ex;
      diff_type [3:0]  ey;
      coord_type [3:0] xi;
      coord_type [3:0] yi;
      common_type      c;
   } f3_type;

   typedef struct packed {
      logic [3:0]                ok;
      logic [3:0][MagWidth-1:0]  an;
      logic [3:0][MagWidth-1:0]  ad;
      diff_type [3:0]            ex;
      diff_type [3:0]            ey;
      coord_type [3:0]           xi;
      coord_type [3:0]           yi;
      common_type                c;
   } f4_type;

   f1_type    s1_in, s1_ff;
   f2_type    s2_in, s2_ff;
   f3_type    s3_in, s3_ff;
   f4_type    s4_in, s4_ff;
   front_type s5_in, s5_ff;
   logic [4:0] v_ff;

   // stage 1: edge vectors and offsets from the point
   always_comb begin
      logic [1:0] j;
      j = 2'd0;
      for (int e = 0; e < Edges; e++) begin
         j = 2'(e + 1);
         if (e == 2 && in_data.is_tri) begin
            j = 2'd0;
         end
         s1_in.ex[e] = DiffWidth'(in_data.x[j]) - DiffWidth'(in_data.x[e]);
         s1_in.ey[e] = DiffWidth'(in_data.y[j]) - DiffWidth'(in_data.y[e]);
         s1_in.ax[e] = DiffWidth'(in_data.x[e]) - DiffWidth'(in_data.px);
         s1_in.ay[e] = DiffWidth'(in_data.y[e]) - DiffWidth'(in_data.py);
         s1_in.xi[e] = in_data.x[e];
         s1_in.yi[e] = in_data.y[e];
      end
      s1_in.vx         = in_data.vx;
      s1_in.vy         = in_data.vy;
      s1_in.c.zero_vel = (in_data.vx == '0) && (in_data.vy == '0);
      s1_in.c.is_tri   = in_data.is_tri;
      s1_in.c.zdx      = DiffWidth'(in_data.x[2]) - DiffWidth'(in_data.x[0]);
      s1_in.c.zdy      = DiffWidth'(in_data.y[2]) - DiffWidth'(in_data.y[0]);
   end

   // stage 2: cross products
   always_comb begin
      for (int e = 0; e < Edges; e++) begin
         s2_in.p1[e] = s1_ff.ex[e] * s1_ff.vy;
         s2_in.p2[e] = s1_ff.ey[e] * s1_ff.vx;
         s2_in.p3[e] = s1_ff.ay[e] * s1_ff.vx;
         s2_in.p4[e] = s1_ff.ax[e] * s1_ff.vy;
      end
      s2_in.ex = s1_ff.ex;
      s2_in.ey = s1_ff.ey;
      s2_in.xi = s1_ff.xi;
      s2_in.yi = s1_ff.yi;
      s2_in.c  = s1_ff.c;
   end

   // stage 3: denominator and numerator of the edge parameter
   always_comb begin
      for (int e = 0; e < Edges; e++) begin
         s3_in.den[e] = WideWidth'(s2_ff.p1[e]) - WideWidth'(s2_ff.p2[e]);
         s3_in.num[e] = WideWidth'(s2_ff.p3[e]) - WideWidth'(s2_ff.p4[e]);
      end
      s3_in.ex = s2_ff.ex;
      s3_in.ey = s2_ff.ey;
      s3_in.xi = s2_ff.xi;
      s3_in.yi = s2_ff.yi;
      s3_in.c  = s2_ff.c;
   end

   // stage 4: parallel and sign tests, magnitudes
   always_comb begin
      wide_type nn, nd;
      nn = '0;
      nd = '0;
      for (int e = 0; e < Edges; e++) begin
         nn = -s3_ff.num[e];
         nd = -s3_ff.den[e];
         s4_in.ok[e] = (s3_ff.den[e] != '0) &&
                       ((s3_ff.num[e] == '0) ||
                        (s3_ff.num[e][WideWidth-1] == s3_ff.den[e][WideWidth-1]));
         // closing edge of a quadrilateral does not exist on a triangle
         if (e == 3 && s3_ff.c.is_tri) begin
            s4_in.ok[e] = 1'b0;
         end
         s4_in.an[e] = MagWidth'(s3_ff.num[e][WideWidth-1] ? nn : s3_ff.num[e]);
         s4_in.ad[e] = MagWidth'(s3_ff.den[e][WideWidth-1] ? nd : s3_ff.den[e]);
      end
      s4_in.ex = s3_ff.ex;
      s4_in.ey = s3_ff.ey;
      s4_in.xi = s3_ff.xi;
      s4_in.yi = s3_ff.yi;
      s4_in.c  = s3_ff.c;
   end

   // stage 5: range test 0 <= t <= 1, divider seed
   always_comb begin
      for (int e = 0; e < Edges; e++) begin
         s5_in.e[e].ok  = s4_ff.ok[e] && (s4_ff.an[e] <= s4_ff.ad[e]);
         s5_in.e[e].eq  = (s4_ff.an[e] == s4_ff.ad[e]);
         s5_in.e[e].ad  = s4_ff.ad[e];
         s5_in.e[e].rem = RemWidth'(s4_ff.an[e]);
         s5_in.e[e].q   = '0;
         s5_in.e[e].ex  = s4_ff.ex[e];
         s5_in.e[e].ey  = s4_ff.ey[e];
         s5_in.e[e].xi  = s4_ff.xi[e];
         s5_in.e[e].yi  = s4_ff.yi[e];
      end
      s5_in.c = s4_ff.c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
      end
   end

   assign out_valid = v_ff[4];
   assign out_data  = s5_ff;

endmodule

// ===== rtl/esl_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esl_divider
// Restoring divider for the edge parameter, four lanes side by side,
// one quotient bit per register stage.
// ----------------------------------------------------------------------------
module esl_divider import esl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  front_type in_data,
   output logic      out_valid,
   output front_type out_data
);

   front_type  st_in [TBits+1];
   front_type  st_ff [TBits];
   logic [TBits-1:0] v_ff;

   assign st_in[0] = in_data;

   for (genvar k = 0; k < TBits; k++) begin : g_step
      front_type nxt;

      // one quotient bit per lane
      always_comb begin
         logic [RemWidth-1:0] r2;
         logic [RemWidth-1:0] ad;
         r2  = '0;
         ad  = '0;
         nxt = st_in[k];
         for (int e = 0; e < Edges; e++) begin
            r2 = {st_in[k].e[e].rem[MagWidth-1:0], 1'b0};
            ad = RemWidth'(st_in[k].e[e].ad);
            if (r2 >= ad) begin
               nxt.e[e].rem = r2 - ad;
               nxt.e[e].q   = {st_in[k].e[e].q[TBits-2:0], 1'b1};
            end else begin
               nxt.e[e].rem = r2;
               nxt.e[e].q   = {st_in[k].e[e].q[TBits-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[k] <= nxt;
         end
      end

      assign st_in[k+1] = st_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[TBits-2:0], in_valid};
      end
   end

   assign out_valid = v_ff[TBits-1];
   assign out_data  = st_in[TBits];

endmodule

// ===== rtl/esl_cut.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esl_cut
// Cut points, choice of the first two, rounded difference and squared
// length. Seven register stages.
// ----------------------------------------------------------------------------
module esl_cut import esl_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      en,
   input  logic      in_valid,
   input  front_type in_data,
   output logic      out_valid,
   output sq_type    out_data
);

   typedef logic signed [RoundWidth-1:0] round_type;

   typedef struct packed {
      logic [3:0]      ok;
      cut_type [3:0]   px;
      cut_type [3:0]   py;
      coord_type [3:0] xi;
      coord_type [3:0] yi;
      common_type      c;
   } c1_type;

   typedef struct packed {
      logic [3:0]    ok;
      cut_type [3:0] cx;
      cut_type [3:0] cy;
      common_type    c;
   } c2_type;

   typedef struct packed {
      logic       two;
      cut_type    c0x;
      cut_type    c0y;
      cut_type    c1x;
      cut_type    c1y;
      common_type c;
   } c3_type;

   typedef struct packed {
      logic       two;
      round_type  dx;
      round_type  dy;
      common_type c;
   } c4_type;

   typedef struct packed {
      logic                two;
      logic                zero_vel;
      logic                big;
      logic [LenWidth-1:0] mx;
      logic [LenWidth-1:0] my;
   } c5_type;

   typedef struct packed {
      logic               two;
      logic               zero_vel;
      logic               big;
      logic [SqWidth-1:0] sx;
      logic [SqWidth-1:0] sy;
   } c6_type;

   localparam logic signed [CutWidth:0] HalfUlp = (CutWidth+1)'(1) <<< (TBits - 1);

   c1_type s1_in, s1_ff;
   c2_type s2_in, s2_ff;
   c3_type s3_in, s3_ff;
   c4_type s4_in, s4_ff;
   c5_type s5_in, s5_ff;
   c6_type s6_in, s6_ff;
   sq_type s7_in, s7_ff;
   logic [6:0] v_ff;

   // stage 1: quantised parameter times edge vector
   always_comb begin
      logic signed [TBits+1:0] t;
      t = '0;
      for (int e = 0; e < Edges; e++) begin
         t = in_data.e[e].eq ? ((TBits+2)'(1) <<< TBits)
                             : (TBits+2)'($unsigned(in_data.e[e].q));
         s1_in.ok[e] = in_data.e[e].ok;
         s1_in.px[e] = in_data.e[e].ex * t;
         s1_in.py[e] = in_data.e[e].ey * t;
         s1_in.xi[e] = in_data.e[e].xi;
         s1_in.yi[e] = in_data.e[e].yi;
      end
      s1_in.c = in_data.c;
   end

   // stage 2: cut positions, scaled by 2^32
   always_comb begin
      for (int e = 0; e < Edges; e++) begin
         s2_in.cx[e] = (CutWidth'(s1_ff.xi[e]) <<< TBits) + s1_ff.px[e];
         s2_in.cy[e] = (CutWidth'(s1_ff.yi[e]) <<< TBits) + s1_ff.py[e];
      end
      s2_in.ok = s1_ff.ok;
      s2_in.c  = s1_ff.c;
   end

   // stage 3: first two cuts in edge order
   always_comb begin
      logic [1:0] cnt;
      cnt       = '0;
      s3_in.c0x = '0;
      s3_in.c0y = '0;
      s3_in.c1x = '0;
      s3_in.c1y = '0;
      for (int e = 0; e < Edges; e++) begin
         if (s2_ff.ok[e] && cnt == 2'd0) begin
            s3_in.c0x = s2_ff.cx[e];
            s3_in.c0y = s2_ff.cy[e];
            cnt       = 2'd1;
         end else if (s2_ff.ok[e] && cnt == 2'd1) begin
            s3_in.c1x = s2_ff.cx[e];
            s3_in.c1y = s2_ff.cy[e];
            cnt       = 2'd2;
         end
      end
      s3_in.two = (cnt == 2'd2);
      s3_in.c   = s2_ff.c;
   end

   // stage 4: difference rounded half up to the coordinate grid
   always_comb begin
      logic signed [CutWidth:0] sx, sy;
      sx = (CutWidth+1)'(s3_ff.c1x) - (CutWidth+1)'(s3_ff.c0x) + HalfUlp;
      sy = (CutWidth+1)'(s3_ff.c1y) - (CutWidth+1)'(s3_ff.c0y) + HalfUlp;
      s4_in.dx  = sx[CutWidth:TBits];
      s4_in.dy  = sy[CutWidth:TBits];
      s4_in.two = s3_ff.two;
      s4_in.c   = s3_ff.c;
   end

   // stage 5: magnitudes, zero-velocity fallback selects the diagonal
   always_comb begin
      round_type ax, ay, nx, ny;
      ax = s4_ff.c.zero_vel ? RoundWidth'(s4_ff.c.zdx) : s4_ff.dx;
      ay = s4_ff.c.zero_vel ? RoundWidth'(s4_ff.c.zdy) : s4_ff.dy;
      nx = -ax;
      ny = -ay;
      if (ax[RoundWidth-1]) begin
         ax = nx;
      end
      if (ay[RoundWidth-1]) begin
         ay = ny;
      end
      s5_in.big      = (|ax[RoundWidth-1:LenWidth]) || (|ay[RoundWidth-1:LenWidth]);
      s5_in.mx       = ax[LenWidth-1:0];
      s5_in.my       = ay[LenWidth-1:0];
      s5_in.two      = s4_ff.two;
      s5_in.zero_vel = s4_ff.c.zero_vel;
   end

   // stage 6: squares
   always_comb begin
      s6_in.sx       = SqWidth'(s5_ff.mx) * SqWidth'(s5_ff.mx);
      s6_in.sy       = SqWidth'(s5_ff.my) * SqWidth'(s5_ff.my);
      s6_in.big      = s5_ff.big;
      s6_in.two      = s5_ff.two;
      s6_in.zero_vel = s5_ff.zero_vel;
   end

   // stage 7: sum of squares, saturation and status
   always_comb begin
      logic [SqWidth:0] n;
      n          = (SqWidth+1)'(s6_ff.sx) + (SqWidth+1)'(s6_ff.sy);
      s7_in.n    = n[SqWidth-1:0];
      s7_in.sat  = s6_ff.big || n[SqWidth];
      s7_in.rem  = '0;
      s7_in.root = '0;
      if (s6_ff.zero_vel) begin
         s7_in.status = StatusZeroVel;
      end else if (s6_ff.two) begin
         s7_in.status = StatusCut;
      end else begin
         s7_in.status = StatusNoCut;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[5:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
      end
   end

   assign out_valid = v_ff[6];
   assign out_data  = s7_ff;

endmodule

// ===== rtl/esl_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esl_sqrt
// Integer square root, one root bit per register stage, with the final
// saturation and status selection.
// ----------------------------------------------------------------------------
module esl_sqrt import esl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       en,
   input  logic       in_valid,
   input  sq_type     in_data,
   output logic       out_valid,
   output result_type out_data
);

   sq_type st_in [LenWidth+1];
   sq_type st_ff [LenWidth];
   logic [LenWidth-1:0] v_ff;

   assign st_in[0] = in_data;

   for (genvar k = 0; k < LenWidth; k++) begin : g_step
      sq_type nxt;

      // bring down two radicand bits, try root*4+1
      always_comb begin
         logic [SrWidth-1:0] rin, t;
         nxt = st_in[k];
         rin = {st_in[k].rem[LenWidth-1:0], st_in[k].n[SqWidth-1 -: 2]};
         t   = {st_in[k].root, 2'b01};
         nxt.n = {st_in[k].n[SqWidth-3:0], 2'b00};
         if (rin >= t) begin
            nxt.rem  = rin - t;
            nxt.root = {st_in[k].root[LenWidth-2:0], 1'b1};
         end else begin
            nxt.rem  = rin;
            nxt.root = {st_in[k].root[LenWidth-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[k] <= nxt;
         end
      end

      assign st_in[k+1] = st_ff[k];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[LenWidth-2:0], in_valid};
      end
   end

   // final length: no cut gives zero, overflow saturates
   always_comb begin
      out_data.status = st_in[LenWidth].status;
      if (st_in[LenWidth].status == StatusNoCut) begin
         out_data.length = '0;
      end else if (st_in[LenWidth].sat) begin
         out_data.length = '1;
      end else begin
         out_data.length = st_in[LenWidth].root;
      end
   end

   assign out_valid = v_ff[LenWidth-1];

endmodule

// ===== rtl/element_stream_length.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// element_stream_length
// Length of the flow line through a triangle or quadrilateral element.
// ----------------------------------------------------------------------------
// Each request on req_ carries the four corners, the velocity and the
// reference point of one element (signed Q16.16). The line through the point
// along the velocity is cut with the element edges in order; the distance
// between the first two cuts comes back on rsp_ with a status in rsp_tuser.
// Zero velocity returns the corner 0 to corner 2 distance, fewer than two
// cuts returns length 0 with the no-cut status.
// The csr_ port holds corner_count at address 0 (3 = triangle, else quad);
// write it only while no request is in flight.
// Throughput: one request per cycle while req_tready is high. Accepted
// requests pass 5 set-up stages, the 32-stage edge parameter divider, 7 cut
// and square stages, the 32-stage square root and the output register.
// A stalled receiver fills the output register and then a skid register;
// req_tready drops only once the skid register is full, and the whole
// pipeline holds. Reset empties the pipeline and sets corner_count to 4.
// ----------------------------------------------------------------------------
module element_stream_length import esl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   // request: node0_x, node0_y, .. node3_x, node3_y, vel_x, vel_y,
   // point_x, point_y, 32 bits each from the lowest bit up
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [383:0] req_tdata,
   // response: stream_length [31:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata,
   // response: length_status [1:0]
   output logic [1:0]   rsp_tuser,
   // configuration
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   logic [2:0] corner_count_ff;
   logic       en;
   elem_type   elem;
   logic       fv, dv, cv, sv;
   front_type  fd, dd;
   sq_type     cd;
   result_type sd;
   logic       out_valid_ff, skid_valid_ff;
   result_type out_data_ff, skid_data_ff;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         corner_count_ff <= CornersReset;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == RegCornerCount) begin
         corner_count_ff <= csr_pwdata[2:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == RegCornerCount) ? {29'd0, corner_count_ff} : '0;

   // request unpacking
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         elem.x[i] = req_tdata[64*i +: 32];
         elem.y[i] = req_tdata[64*i+32 +: 32];
      end
      elem.vx     = req_tdata[256 +: 32];
      elem.vy     = req_tdata[288 +: 32];
      elem.px     = req_tdata[320 +: 32];
      elem.py     = req_tdata[352 +: 32];
      elem.is_tri = (corner_count_ff == CornersTri);
   end

   // pipeline moves whenever the skid register is free
   assign en         = !skid_valid_ff;
   assign req_tready = en;

   esl_front u_front (
      .clock, .reset, .en,
      .in_valid (req_tvalid && req_tready), .in_data (elem),
      .out_valid (fv), .out_data (fd)
   );

   esl_divider u_divider (
      .clock, .reset, .en,
      .in_valid (fv), .in_data (fd),
      .out_valid (dv), .out_data (dd)
   );

   esl_cut u_cut (
      .clock, .reset, .en,
      .in_valid (dv), .in_data (dd),
      .out_valid (cv), .out_data (cd)
   );

   esl_sqrt u_sqrt (
      .clock, .reset, .en,
      .in_valid (cv), .in_data (cd),
      .out_valid (sv), .out_data (sd)
   );

   // output register with skid stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (en) begin
         if (out_valid_ff && !rsp_tready) begin
            skid_valid_ff <= sv;
         end else begin
            out_valid_ff <= sv;
         end
      end else if (rsp_tready) begin
         skid_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (out_valid_ff && !rsp_tready) begin
            skid_data_ff <= sd;
         end else begin
            out_data_ff <= sd;
         end
      end else if (rsp_tready) begin
         out_data_ff <= skid_data_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff.length;
   assign rsp_tuser  = out_data_ff.status;

   // skid register only holds a request behind a waiting output
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full with output register empty");

   a_skid_on_stall : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && !rsp_tready))
      else $error("skid register filled without a stall");

   a_no_cut_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == StatusNoCut) |-> (rsp_tdata == '0))
      else $error("no-cut response with non-zero length");

endmodule
